@@ rtl/core/ddm_pkg.sv @@
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared types and constants of the differential drive mixer.
// ----------------------------------------------------------------------------
package ddm_pkg;

  localparam logic [2:0] REG_ENABLE     = 3'd0;
  localparam logic [2:0] REG_BASE_SPEED = 3'd1;
  localparam logic [2:0] REG_MIN_SPEED  = 3'd2;
  localparam logic [2:0] REG_LEFT_GAIN  = 3'd3;
  localparam logic [2:0] REG_RIGHT_GAIN = 3'd4;

  localparam logic [16:0] SIN_A = 17'd51472;
  localparam logic [14:0] SIN_B = 15'd21024;
  localparam logic [11:0] SIN_C = 12'd2320;
  localparam logic [16:0] MAG_ONE = 17'd32768;

  // Classified command passed from the front part to the back part.
  typedef struct packed {
    logic        active;
    logic [15:0] mag;
    logic [15:0] ang;
  } ddm_item_t;

endpackage

@@ rtl/core/ddm_front.sv @@
// ----------------------------------------------------------------------------
// ddm_front
// Accepts commands, classifies them as drive or stop and queues them.
// ----------------------------------------------------------------------------
module ddm_front #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               cmd,
  input  logic [15:0]        magnitude,
  input  logic [15:0]        heading,
  input  logic               enable,
  input  logic               take,
  output logic               have,
  output ddm_pkg::ddm_item_t item
);
  import ddm_pkg::*;

  localparam int DROP = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam logic [15:0] ANG_MASK = 16'hFFFF << DROP;

  ddm_item_t q [2];
  logic      wptr;
  logic      rptr;
  logic [1:0] count;
  ddm_item_t in_item;

  always_comb begin
    in_item.active = !cmd && enable;
    in_item.mag    = (magnitude > MAG_ONE[15:0]) ? MAG_ONE[15:0] : magnitude;
    in_item.ang    = heading & ANG_MASK;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (start) begin
        wptr <= !wptr;
      end
      if (take) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, start} - {1'b0, take};
    end
  end

  assign have = (count != 2'd0);
  assign item = q[rptr];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue overflow");
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    take |-> have) else $error("take from empty queue");
  a_count_move: assert property (@(posedge clk) disable iff (rst)
    (start && !take) |=> count == $past(count) + 2'd1) else $error("count slip");
`endif

endmodule

@@ rtl/core/ddm_back.sv @@
// ----------------------------------------------------------------------------
// ddm_back
// Pipelined sine, mixing, scaling, gain, clamp and bridge output stages.
// ----------------------------------------------------------------------------
module ddm_back #(
  parameter int PWM_MAX = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               have,
  input  ddm_pkg::ddm_item_t item,
  input  logic [7:0]         base_speed,
  input  logic [7:0]         min_speed,
  input  logic [14:0]        left_gain,
  input  logic [14:0]        right_gain,
  output logic               take,
  output logic               done,
  output logic signed [8:0]  left_speed,
  output logic signed [8:0]  right_speed,
  output logic               left_in1,
  output logic               left_in2,
  output logic [7:0]         left_duty,
  output logic               right_in1,
  output logic               right_in2,
  output logic [7:0]         right_duty
);
  import ddm_pkg::*;

  localparam logic signed [17:0] PMAX = 18'(PWM_MAX);

  // Stage valid and active bits.
  logic [7:0] v;
  logic [7:0] act;

  assign take = have;

  // Stage 0: quadrant split for cos (c) and sin (s).
  logic [15:0] ang_c;
  logic [14:0] zc0, zs0;
  logic        nc0, ns0;
  logic [15:0] mag0;
  assign ang_c = item.ang + 16'h4000;

  always_ff @(posedge clk) begin
    zc0  <= ang_c[14] ? 15'(15'd16384 - {1'b0, ang_c[13:0]}) : {1'b0, ang_c[13:0]};
    zs0  <= item.ang[14] ? 15'(15'd16384 - {1'b0, item.ang[13:0]})
                         : {1'b0, item.ang[13:0]};
    nc0  <= ang_c[15];
    ns0  <= item.ang[15];
    mag0 <= item.mag;
  end

  // Stage 1: z2.
  logic [14:0] zc1, zs1, z2c1, z2s1;
  logic        nc1, ns1;
  logic [15:0] mag1;
  logic [29:0] pc1, ps1;
  assign pc1 = zc0 * zc0;
  assign ps1 = zs0 * zs0;
  always_ff @(posedge clk) begin
    zc1 <= zc0; zs1 <= zs0;
    z2c1 <= pc1[28:14]; z2s1 <= ps1[28:14];
    nc1 <= nc0; ns1 <= ns0; mag1 <= mag0;
  end

  // Stage 2: t = B - (C*z2 >> 14).
  logic [14:0] zc2, zs2, z2c2, z2s2, tc2, ts2;
  logic        nc2, ns2;
  logic [15:0] mag2;
  logic [26:0] qc2, qs2;
  assign qc2 = SIN_C * z2c1;
  assign qs2 = SIN_C * z2s1;
  always_ff @(posedge clk) begin
    zc2 <= zc1; zs2 <= zs1; z2c2 <= z2c1; z2s2 <= z2s1;
    tc2 <= SIN_B - 15'(qc2[26:14]);
    ts2 <= SIN_B - 15'(qs2[26:14]);
    nc2 <= nc1; ns2 <= ns1; mag2 <= mag1;
  end

  // Stage 3: t = A - (t*z2 >> 14).
  logic [14:0] zc3, zs3;
  logic [16:0] tc3, ts3;
  logic        nc3, ns3;
  logic [15:0] mag3;
  logic [29:0] rc3, rs3;
  assign rc3 = tc2 * z2c2;
  assign rs3 = ts2 * z2s2;
  always_ff @(posedge clk) begin
    zc3 <= zc2; zs3 <= zs2;
    tc3 <= SIN_A - 17'(rc3[29:14]);
    ts3 <= SIN_A - 17'(rs3[29:14]);
    nc3 <= nc2; ns3 <= ns2; mag3 <= mag2;
  end

  // Stage 4: signed sine and cosine in Q15.
  logic signed [16:0] cs4, sn4;
  logic [15:0]        mag4;
  logic [31:0]        yc4, ys4;
  assign yc4 = zc3 * tc3;
  assign ys4 = zs3 * ts3;
  always_ff @(posedge clk) begin
    cs4  <= nc3 ? -$signed({1'b0, yc4[29:14]}) : $signed({1'b0, yc4[29:14]});
    sn4  <= ns3 ? -$signed({1'b0, ys4[29:14]}) : $signed({1'b0, ys4[29:14]});
    mag4 <= mag3;
  end

  // Stage 5: forward and turn products and wheel mixes.
  logic signed [33:0] fw5, tn5;
  logic signed [34:0] lmix5, rmix5;
  assign fw5 = $signed({1'b0, mag4}) * cs4;
  assign tn5 = $signed({1'b0, mag4}) * sn4;
  always_ff @(posedge clk) begin
    lmix5 <= 35'(fw5) + 35'(tn5);
    rmix5 <= 35'(fw5) - 35'(tn5);
  end

  // Stage 6: scale by base speed, truncate toward zero.
  logic signed [43:0] ls6p, rs6p;
  logic signed [13:0] lraw6, rraw6;
  assign ls6p = lmix5 * $signed({1'b0, base_speed});
  assign rs6p = rmix5 * $signed({1'b0, base_speed});

  function automatic logic signed [13:0] q30_trunc(input logic signed [43:0] p);
    logic signed [13:0] r;
    begin
      r = p[43:30];
      if (p[43] && (p[29:0] != '0)) begin
        r = r + 14'sd1;
      end
      return r;
    end
  endfunction

  always_ff @(posedge clk) begin
    lraw6 <= q30_trunc(ls6p);
    rraw6 <= q30_trunc(rs6p);
  end

  // Stage 7: gain, truncate toward zero, clamp, minimum, outputs.
  logic signed [29:0] lg7, rg7;
  logic [7:0]         eff_min;
  assign lg7 = lraw6 * $signed({1'b0, left_gain});
  assign rg7 = rraw6 * $signed({1'b0, right_gain});
  assign eff_min = (min_speed < base_speed) ? min_speed : base_speed;

  function automatic logic signed [17:0] shape(input logic signed [29:0] p,
                                               input logic [7:0] emin);
    logic signed [17:0] g;
    logic signed [17:0] m;
    begin
      g = 18'(p >>> 14);
      if (p[29] && (p[13:0] != '0)) begin
        g = g + 18'sd1;
      end
      m = $signed({10'd0, emin});
      if (g > PMAX) begin
        g = PMAX;
      end else if (g < -PMAX) begin
        g = -PMAX;
      end
      if (g > 0 && g < m) begin
        g = m;
      end else if (g < 0 && g > -m) begin
        g = -m;
      end
      return g;
    end
  endfunction

  logic signed [17:0] lsp, rsp, lcl, rcl;
  assign lsp = shape(lg7, eff_min);
  assign rsp = shape(rg7, eff_min);
  assign lcl = (lsp > PMAX) ? PMAX : ((lsp < -PMAX) ? -PMAX : lsp);
  assign rcl = (rsp > PMAX) ? PMAX : ((rsp < -PMAX) ? -PMAX : rsp);

  always_ff @(posedge clk) begin
    if (act[6]) begin
      left_speed  <= lsp[8:0];
      right_speed <= rsp[8:0];
      left_in1    <= lcl > 0;
      left_in2    <= !(lcl > 0);
      left_duty   <= lcl[17] ? 8'(-lcl) : lcl[7:0];
      right_in1   <= rcl > 0;
      right_in2   <= !(rcl > 0);
      right_duty  <= rcl[17] ? 8'(-rcl) : rcl[7:0];
    end else begin
      left_speed  <= '0;
      right_speed <= '0;
      left_in1    <= 1'b0;
      left_in2    <= 1'b0;
      left_duty   <= '0;
      right_in1   <= 1'b0;
      right_in2   <= 1'b0;
      right_duty  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v   <= '0;
      act <= '0;
    end else begin
      v   <= {v[6:0], take};
      act <= {act[6:0], take && item.active};
    end
  end

  assign done = v[7];

`ifndef SYNTHESIS
  a_act_in_v: assert property (@(posedge clk) disable iff (rst)
    (act & ~v) == 8'd0) else $error("active bit without valid item");
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    (done && !act[7]) |-> (left_duty == 8'd0 && right_duty == 8'd0))
    else $error("stop result with duty");
  a_bits: assert property (@(posedge clk) disable iff (rst)
    done |-> !(left_in1 && left_in2) && !(right_in1 && right_in2))
    else $error("bridge bits both high");
`endif

endmodule

@@ rtl/core/differential_drive_mixer.sv @@
// ----------------------------------------------------------------------------
// differential_drive_mixer
// Polar drive command to two-wheel speeds, bridge bits and PWM duties.
// ----------------------------------------------------------------------------
// A command is taken on any cycle with start high; busy is never raised, so a
// new command may follow every cycle. Each command gives one result, shown
// with done for a single cycle; on its way from the transfer it passes the
// command queue, the quadrant split, the sine polynomial and the product,
// scale and gain multipliers, each registered. The receiver cannot stall the
// result. Write registers via cfg_valid, cfg_ready, cfg_index and cfg_data
// only while no command is in flight; the block does not enforce this.
module differential_drive_mixer #(
  parameter int PWM_MAX    = 255,
  parameter int ANGLE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cmd,
  input  logic [15:0]       magnitude,
  input  logic [15:0]       heading,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [14:0]       cfg_data,
  output logic              done,
  output logic signed [8:0] left_speed,
  output logic signed [8:0] right_speed,
  output logic              left_in1,
  output logic              left_in2,
  output logic [7:0]        left_duty,
  output logic              right_in1,
  output logic              right_in2,
  output logic [7:0]        right_duty
);
  import ddm_pkg::*;

  logic        enable;
  logic [7:0]  base_speed;
  logic [7:0]  min_speed;
  logic [14:0] left_gain;
  logic [14:0] right_gain;
  logic        have;
  logic        take;
  ddm_item_t   item;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      base_speed <= 8'd200;
      min_speed  <= 8'd0;
      left_gain  <= 15'd16384;
      right_gain <= 15'd16384;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:     enable     <= cfg_data[0];
        REG_BASE_SPEED: base_speed <= cfg_data[7:0];
        REG_MIN_SPEED:  min_speed  <= cfg_data[7:0];
        REG_LEFT_GAIN:  left_gain  <= cfg_data;
        REG_RIGHT_GAIN: right_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  ddm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .magnitude(magnitude),
    .heading(heading), .enable(enable), .take(take), .have(have), .item(item)
  );

  ddm_back #(.PWM_MAX(PWM_MAX)) u_back (
    .clk(clk), .rst(rst), .have(have), .item(item), .base_speed(base_speed),
    .min_speed(min_speed), .left_gain(left_gain), .right_gain(right_gain),
    .take(take), .done(done), .left_speed(left_speed),
    .right_speed(right_speed), .left_in1(left_in1), .left_in2(left_in2),
    .left_duty(left_duty), .right_in1(right_in1), .right_in2(right_in2),
    .right_duty(right_duty)
  );

endmodule
